/* hdl/event_timing_statistics_table_assert.svh */
// assertion macros for the event timing statistics table
// included by modules that carry concurrent checks, no other dependencies
`ifndef EVENT_TIMING_STATISTICS_TABLE_ASSERT_SVH
`define EVENT_TIMING_STATISTICS_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ETST_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("etst check failed");

// next-cycle implication
`define ETST_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("etst check failed");

`else

`define ETST_ASSERT_IMP(label, clk, rst, ante, cons)
`define ETST_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/etst_pkg.sv */
// shared types, constants and reset value for the event timing statistics table
// no dependencies
package etst_pkg;

  localparam int SLOT_COUNT_DEF = 256;
  localparam int TIME_BITS_DEF  = 64;
  localparam int SLOT_BITS      = 8;
  localparam int STAT_BITS      = 64;
  localparam int COUNT_BITS     = 32;
  localparam int HALF_BITS      = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [SLOT_BITS-1:0] slot_index;
    logic [STAT_BITS-1:0] parent_start_time;
    logic [STAT_BITS-1:0] begin_time;
    logic [STAT_BITS-1:0] end_time;
  } item_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count_out;
    logic [STAT_BITS-1:0]  duration_sum_out;
    logic [STAT_BITS-1:0]  duration_square_sum_out;
    logic [STAT_BITS-1:0]  duration_min_out;
    logic [STAT_BITS-1:0]  duration_max_out;
    logic [STAT_BITS-1:0]  offset_sum_out;
    logic [STAT_BITS-1:0]  offset_square_sum_out;
    logic [STAT_BITS-1:0]  offset_min_out;
    logic [STAT_BITS-1:0]  offset_max_out;
  } stats_t;

  // classified beat passed from front to back
  typedef struct packed {
    logic [SLOT_BITS-1:0] slot_index;
    logic [STAT_BITS-1:0] offset;
    logic [STAT_BITS-1:0] duration;
  } work_t;

  function automatic stats_t stats_reset();
    stats_t r;
    r = '0;
    r.duration_min_out = '1;
    r.offset_min_out   = '1;
    return r;
  endfunction

endpackage

/* hdl/etst_front.sv */
// front end: accepts input beats, wraps the slot and forms offset and duration
// depends on etst_pkg
module etst_front import etst_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  item_t item,
  input  logic  item_valid,
  output logic  item_stall,
  input  logic  clearing,
  output work_t work,
  output logic  work_valid,
  input  logic  work_stall
);

  localparam int LUT_SIZE = 1 << SLOT_BITS;

  logic [SLOT_BITS-1:0] slot_lut [LUT_SIZE];
  logic [TIME_BITS-1:0] offset_w;
  logic [TIME_BITS-1:0] duration_w;
  logic                 accept;

  for (genvar g = 0; g < LUT_SIZE; g++) begin : g_slot_lut
    assign slot_lut[g] = SLOT_BITS'(g % SLOT_COUNT);
  end

  assign offset_w   = item.begin_time[TIME_BITS-1:0] - item.parent_start_time[TIME_BITS-1:0];
  assign duration_w = item.end_time[TIME_BITS-1:0] - item.begin_time[TIME_BITS-1:0];

  assign item_stall = clearing || (work_valid && work_stall);
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (accept) begin
      work_valid <= 1'b1;
    end else if (!work_stall) begin
      work_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work.slot_index <= slot_lut[item.slot_index];
      work.offset     <= STAT_BITS'(offset_w);
      work.duration   <= STAT_BITS'(duration_w);
    end
  end

endmodule

/* hdl/etst_queue.sv */
// short queue between front and back end
// depends on etst_pkg
module etst_queue import etst_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  work_t push_data,
  input  logic  push_valid,
  output logic  push_stall,
  output work_t pop_data,
  output logic  pop_valid,
  input  logic  pop_stall
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

  work_t               entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                push;
  logic                pop;

  assign push_stall = (count == CNT_FULL);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

/* hdl/etst_back.sv */
// back end: statistics memory, clearing pass, shared multiplier and update
// depends on etst_pkg and event_timing_statistics_table_assert.svh
`include "event_timing_statistics_table_assert.svh"

module etst_back import etst_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  work_t  work,
  input  logic   work_valid,
  output logic   work_stall,
  output logic   clearing,
  output stats_t stats,
  output logic   stats_valid,
  input  logic   stats_stall
);

  localparam int USED_SLOTS = (SLOT_COUNT < (1 << SLOT_BITS)) ? SLOT_COUNT : (1 << SLOT_BITS);
  localparam int ADDR_BITS  = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
  localparam logic [ADDR_BITS-1:0] ADDR_LAST = ADDR_BITS'(USED_SLOTS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_MUL    = 5'b00100,
    ST_SQUARE = 5'b01000,
    ST_UPDATE = 5'b10000
  } state_t;

  state_t                state;
  stats_t                stat_mem [USED_SLOTS];
  stats_t                cur;
  stats_t                upd;
  stats_t                wr_data;
  work_t                 job;
  logic [ADDR_BITS-1:0]  clr_addr;
  logic [ADDR_BITS-1:0]  wr_addr;
  logic                  mem_we;
  logic                  pop;
  logic                  load;
  logic [1:0]            mul_step;
  logic [HALF_BITS-1:0]  mul_a;
  logic [HALF_BITS-1:0]  mul_b;
  logic [STAT_BITS-1:0]  product;
  logic [STAT_BITS-1:0]  off_ll;
  logic [STAT_BITS-1:0]  dur_ll;
  logic [HALF_BITS-1:0]  off_lh;
  logic [HALF_BITS-1:0]  dur_lh;
  logic [STAT_BITS-1:0]  off_sq;
  logic [STAT_BITS-1:0]  dur_sq;

  assign clearing   = (state == ST_CLEAR);
  assign work_stall = (state != ST_IDLE);
  assign pop        = work_valid && (state == ST_IDLE);
  assign load       = (state == ST_UPDATE) && (!stats_valid || !stats_stall);
  assign mem_we     = clearing || load;
  assign wr_addr    = clearing ? clr_addr : job.slot_index[ADDR_BITS-1:0];
  assign wr_data    = clearing ? stats_reset() : upd;

  // square mod 2^64 from lo*lo and the low half of lo*hi
  always_comb begin
    unique case (mul_step)
      2'd0: begin
        mul_a = job.offset[HALF_BITS-1:0];
        mul_b = job.offset[HALF_BITS-1:0];
      end
      2'd1: begin
        mul_a = job.offset[HALF_BITS-1:0];
        mul_b = job.offset[STAT_BITS-1:HALF_BITS];
      end
      2'd2: begin
        mul_a = job.duration[HALF_BITS-1:0];
        mul_b = job.duration[HALF_BITS-1:0];
      end
      2'd3: begin
        mul_a = job.duration[HALF_BITS-1:0];
        mul_b = job.duration[STAT_BITS-1:HALF_BITS];
      end
    endcase
  end

  assign product = mul_a * mul_b;

  always_comb begin
    upd.count_out = (cur.count_out == COUNT_MAX) ? cur.count_out
                                                 : cur.count_out + COUNT_BITS'(1);
    upd.duration_sum_out        = cur.duration_sum_out + job.duration;
    upd.duration_square_sum_out = cur.duration_square_sum_out + dur_sq;
    upd.duration_min_out        = (job.duration < cur.duration_min_out) ? job.duration
                                                                        : cur.duration_min_out;
    upd.duration_max_out        = (job.duration > cur.duration_max_out) ? job.duration
                                                                        : cur.duration_max_out;
    upd.offset_sum_out          = cur.offset_sum_out + job.offset;
    upd.offset_square_sum_out   = cur.offset_square_sum_out + off_sq;
    upd.offset_min_out          = (job.offset < cur.offset_min_out) ? job.offset
                                                                    : cur.offset_min_out;
    upd.offset_max_out          = (job.offset > cur.offset_max_out) ? job.offset
                                                                    : cur.offset_max_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      mul_step <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_BITS'(1);
          if (clr_addr == ADDR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          mul_step <= '0;
          if (pop) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          mul_step <= mul_step + 2'd1;
          if (mul_step == 2'd3) begin
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= work;
    end
    if (state == ST_MUL) begin
      unique case (mul_step)
        2'd0: off_ll <= product;
        2'd1: off_lh <= product[HALF_BITS-1:0];
        2'd2: dur_ll <= product;
        2'd3: dur_lh <= product[HALF_BITS-1:0];
      endcase
    end
    if (state == ST_SQUARE) begin
      off_sq <= off_ll + {off_lh[HALF_BITS-2:0], {(HALF_BITS + 1){1'b0}}};
      dur_sq <= dur_ll + {dur_lh[HALF_BITS-2:0], {(HALF_BITS + 1){1'b0}}};
    end
    if (load) begin
      stats <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stat_mem[wr_addr] <= wr_data;
    end
    if (pop) begin
      cur <= stat_mem[work.slot_index[ADDR_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stats_valid <= 1'b0;
    end else if (load) begin
      stats_valid <= 1'b1;
    end else if (!stats_stall) begin
      stats_valid <= 1'b0;
    end
  end

  `ETST_ASSERT_IMP(a_count_nonzero, clk, rst, stats_valid, stats.count_out != '0)
  `ETST_ASSERT_IMP(a_dur_order, clk, rst, stats_valid, stats.duration_min_out <= stats.duration_max_out)
  `ETST_ASSERT_IMP(a_off_order, clk, rst, stats_valid, stats.offset_min_out <= stats.offset_max_out)
  `ETST_ASSERT_NXT(a_pop_starts_mul, clk, rst, pop, (state == ST_MUL) && (mul_step == 2'd0))

endmodule

/* hdl/event_timing_statistics_table.sv */
// event timing statistics table: per-slot count, sum, sum of squares, min, max
// of offset from parent start and of duration
// channels: item/item_valid/item_stall in, stats/stats_valid/stats_stall out
// each accepted item beat yields exactly one stats beat with the slot's
// updated statistics, in order; slot index wraps modulo SLOT_COUNT and
// timestamps are taken in their low TIME_BITS bits
// the back end takes one item at a time and accepts the next only after
// its sequence of memory read, four passes through one shared 32x32
// multiplier, a square step and the update/write-back
// a two-entry queue and a front register absorb items while the back end
// works; item_stall rises once they are full
// after reset a clearing pass writes the reset value to every slot, one
// slot per cycle, across min(SLOT_COUNT, 256) slots; item_stall is high then
// while stats_stall is high the result beat holds and the back end waits
// with its next write-back until the output register frees
// depends on etst_pkg, etst_front, etst_queue, etst_back
module event_timing_statistics_table import etst_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  item_t  item,
  input  logic   item_valid,
  output logic   item_stall,
  output stats_t stats,
  output logic   stats_valid,
  input  logic   stats_stall
);

  work_t front_work;
  logic  front_valid;
  logic  front_stall;
  work_t queue_work;
  logic  queue_valid;
  logic  queue_stall;
  logic  clearing;

  etst_front #(
    .SLOT_COUNT (SLOT_COUNT),
    .TIME_BITS  (TIME_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .clearing   (clearing),
    .work       (front_work),
    .work_valid (front_valid),
    .work_stall (front_stall)
  );

  etst_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (front_work),
    .push_valid (front_valid),
    .push_stall (front_stall),
    .pop_data   (queue_work),
    .pop_valid  (queue_valid),
    .pop_stall  (queue_stall)
  );

  etst_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .work        (queue_work),
    .work_valid  (queue_valid),
    .work_stall  (queue_stall),
    .clearing    (clearing),
    .stats       (stats),
    .stats_valid (stats_valid),
    .stats_stall (stats_stall)
  );

endmodule
